FILE: design/nuc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nuc_pkg;

  localparam int DIM_MAX        = 128;
  localparam int MAX_CANDIDATES = 64;

  localparam int COORD_W      = 16;
  localparam int MAG_W        = COORD_W;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int DIST_W       = 48;
  localparam int BEST_INDEX_W = 6;
  localparam int COORD_CNT_W  = $clog2(DIM_MAX + 1);
  localparam int CAND_CNT_W   = $clog2(MAX_CANDIDATES + 1);

  // Squared coordinate difference with the framing flags of its beat.
  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            last_coord;
    logic            last_candidate;
  } sq_item_t;

endpackage
`default_nettype wire

FILE: design/nuc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface nuc_in_if;
  import nuc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] query_coord;
  logic signed [COORD_W-1:0] cand_coord;
  logic                      last_coord;
  logic                      last_candidate;

  modport source (
    output valid, query_coord, cand_coord, last_coord, last_candidate,
    input  ready
  );

  modport sink (
    input  valid, query_coord, cand_coord, last_coord, last_candidate,
    output ready
  );

endinterface
`default_nettype wire

FILE: design/nuc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface nuc_out_if;
  import nuc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    match_found;
  logic [BEST_INDEX_W-1:0] best_index;
  logic                    overflowed;

  modport source (
    output valid, match_found, best_index, overflowed,
    input  ready
  );

  modport sink (
    input  valid, match_found, best_index, overflowed,
    output ready
  );

endinterface
`default_nettype wire

FILE: design/nearest_unique_candidate_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a closing beat goes through the input, square and result registers in turn.
// Throughput: one coordinate beat per cycle, except that a closing beat stalls while
//   a previous result is untaken; set by the single accumulate and compare loop.
// Reset: synchronous, active low; clears the pipeline valids, the result valid and
//   the search state (best and second-best distances to all ones, counts to zero).
module nearest_unique_candidate_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  nuc_in_if.sink    in_ch,
  nuc_out_if.source out_ch
);
  import nuc_pkg::*;

  // Squared difference handed from the square pipeline to the search stage.
  logic     sq_valid;
  logic     sq_ready;
  sq_item_t sq_item;

  // Register the beat, then form |q - c|^2 into a second register so the
  // multiplier stays off the accumulate loop.
  nuc_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .sq_valid (sq_valid),
    .sq_item  (sq_item),
    .sq_ready (sq_ready)
  );

  // Accumulate per candidate, track best and second best, and emit the
  // uniqueness verdict on the final candidate into the result register.
  // A closing beat waits only while a previous verdict is still untaken.
  nuc_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .sq_valid (sq_valid),
    .sq_item  (sq_item),
    .sq_ready (sq_ready),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

FILE: design/nuc_square.sv
`timescale 1ns / 1ps
`default_nettype none
module nuc_square (
  input  wire logic        clk,
  input  wire logic        rst_n,
  nuc_in_if.sink           in_ch,
  output logic             sq_valid,
  output nuc_pkg::sq_item_t sq_item,
  input  wire logic        sq_ready
);
  import nuc_pkg::*;

  logic                      s0_valid_r;
  logic signed [COORD_W-1:0] query_r;
  logic signed [COORD_W-1:0] cand_r;
  logic                      last_coord_r;
  logic                      last_cand_r;
  logic                      s1_valid_r;
  sq_item_t                  s1_item_r;
  sq_item_t                  s1_item_nxt;

  logic                      s0_ready;
  logic                      s1_ready;
  logic signed [COORD_W:0]   diff;
  logic        [COORD_W:0]   diff_neg;
  logic        [MAG_W-1:0]   mag;

  assign s1_ready    = !s1_valid_r || sq_ready;
  assign s0_ready    = !s0_valid_r || s1_ready;
  assign in_ch.ready = s0_ready;

  // Difference is exact in 17 bits; its magnitude fits in 16.
  always_comb begin
    diff     = {query_r[COORD_W-1], query_r} - {cand_r[COORD_W-1], cand_r};
    diff_neg = -diff;
    mag      = diff[COORD_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
    s1_item_nxt.sq             = mag * mag;
    s1_item_nxt.last_coord     = last_coord_r;
    s1_item_nxt.last_candidate = last_cand_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_r <= in_ch.valid;
      end
      if (s1_ready) begin
        s1_valid_r <= s0_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_ch.valid) begin
      query_r      <= in_ch.query_coord;
      cand_r       <= in_ch.cand_coord;
      last_coord_r <= in_ch.last_coord;
      last_cand_r  <= in_ch.last_candidate;
    end
    if (s1_ready && s0_valid_r) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  assign sq_valid = s1_valid_r;
  assign sq_item  = s1_item_r;

endmodule
`default_nettype wire

FILE: design/nuc_search.sv
`timescale 1ns / 1ps
`default_nettype none
module nuc_search (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               sq_valid,
  input  wire nuc_pkg::sq_item_t  sq_item,
  output logic                    sq_ready,
  nuc_out_if.source               out_ch
);
  import nuc_pkg::*;

  logic [DIST_W-1:0]       accum_r, accum_nxt;
  logic [DIST_W-1:0]       best_r, best_nxt;
  logic [DIST_W-1:0]       second_r, second_nxt;
  logic [BEST_INDEX_W-1:0] best_idx_r, best_idx_nxt;
  logic [CAND_CNT_W-1:0]   cand_cnt_r, cand_cnt_nxt;
  logic [COORD_CNT_W-1:0]  coord_cnt_r, coord_cnt_nxt;
  logic                    ovf_r, ovf_nxt;

  logic                    out_valid_r;
  logic                    match_r, match_nxt;
  logic [BEST_INDEX_W-1:0] index_r, index_nxt;
  logic                    out_ovf_r;

  logic                    take;
  logic                    end_cand;
  logic                    coord_room;
  logic [DIST_W-1:0]       cand_dist;

  // A closing beat needs a free result slot; other beats always flow.
  assign sq_ready = !sq_item.last_candidate || !out_valid_r || out_ch.ready;
  assign take     = sq_valid && sq_ready;
  assign end_cand = sq_item.last_coord || sq_item.last_candidate;

  always_comb begin
    coord_room = coord_cnt_r < COORD_CNT_W'(DIM_MAX);
    cand_dist  = coord_room ? accum_r + DIST_W'(sq_item.sq) : accum_r;

    accum_nxt     = cand_dist;
    coord_cnt_nxt = coord_room ? coord_cnt_r + 1'b1 : coord_cnt_r;
    best_nxt      = best_r;
    second_nxt    = second_r;
    best_idx_nxt  = best_idx_r;
    cand_cnt_nxt  = cand_cnt_r;
    ovf_nxt       = ovf_r;

    if (end_cand) begin
      if (cand_cnt_r < CAND_CNT_W'(MAX_CANDIDATES)) begin
        if (cand_dist < best_r) begin
          second_nxt   = best_r;
          best_nxt     = cand_dist;
          best_idx_nxt = BEST_INDEX_W'(cand_cnt_r);
        end else if (cand_dist < second_r) begin
          second_nxt = cand_dist;
        end
        cand_cnt_nxt = cand_cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
      accum_nxt     = '0;
      coord_cnt_nxt = '0;
    end

    // A lone candidate always matches at index zero.
    if (cand_cnt_nxt <= CAND_CNT_W'(1)) begin
      match_nxt = 1'b1;
      index_nxt = '0;
    end else begin
      match_nxt = best_nxt < second_nxt;
      index_nxt = best_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      best_r      <= '1;
      second_r    <= '1;
      best_idx_r  <= '0;
      cand_cnt_r  <= '0;
      coord_cnt_r <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take && sq_item.last_candidate) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (sq_item.last_candidate) begin
          // Close the set and start the next one from scratch.
          accum_r     <= '0;
          best_r      <= '1;
          second_r    <= '1;
          best_idx_r  <= '0;
          cand_cnt_r  <= '0;
          coord_cnt_r <= '0;
          ovf_r       <= 1'b0;
        end else begin
          accum_r     <= accum_nxt;
          best_r      <= best_nxt;
          second_r    <= second_nxt;
          best_idx_r  <= best_idx_nxt;
          cand_cnt_r  <= cand_cnt_nxt;
          coord_cnt_r <= coord_cnt_nxt;
          ovf_r       <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && sq_item.last_candidate) begin
      match_r   <= match_nxt;
      index_r   <= index_nxt;
      out_ovf_r <= ovf_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.match_found = match_r;
  assign out_ch.best_index  = index_r;
  assign out_ch.overflowed  = out_ovf_r;

endmodule
`default_nettype wire
